>>> sv/tbpwb_pkg.sv
// ----------------------------------------------------------------------------
// tbpwb_pkg: types and constants for the Thumb-2 branch patch word builder
// Holds the request and result word layouts shared by the encoder and the top level,
// and the fixed branch encoding fields used by the encoder.
// ----------------------------------------------------------------------------
package tbpwb_pkg;

	localparam int ADDR_W = 32;
	localparam int WORD_W = 32;
	localparam int HALF_W = 16;
	localparam int SLOT_W = 3;

	// Fixed bits of the two branch halfwords, the comparator enable bits and the word step
	localparam logic [4:0] BR_PREFIX     = 5'b11110;
	localparam logic       BR_LO_TOP     = 1'b1;
	localparam logic       BR_LO_FIXED   = 1'b1;
	localparam logic [1:0] CMP_ENABLE    = 2'b01;
	localparam logic [ADDR_W-1:0] WORD_STEP = 32'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] patch_address;
		logic [ADDR_W-1:0] target_address;
		logic              with_link;
		logic [SLOT_W-1:0] slot_index;
		logic [WORD_W-1:0] original_low_word;
		logic [WORD_W-1:0] original_high_word;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] comparator_value;
		logic [WORD_W-1:0] remap_word;
		logic              offset_out_of_range;
		logic              slot_overflow;
		logic              last;
	} result_t;

endpackage

>>> sv/thumb_branch_patch_word_builder.sv
// ----------------------------------------------------------------------------
// thumb_branch_patch_word_builder: flash patch comparator/remap word builder
// The request is held in the request stage and the result word in a result
// register before reaching the ports. Throughput: 1 request per cycle for single-word
// patches; a two-word half-aligned patch holds busy while the second word reuses the
// held request stage. Results appear for exactly one cycle on result_valid; the
// receiver cannot stall. Reset clears the request and result valid flags and the phase.
// ----------------------------------------------------------------------------
module thumb_branch_patch_word_builder #(
	parameter int SLOT_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tbpwb_pkg::item_t   item,
	output logic               result_valid,
	output tbpwb_pkg::result_t result
);

	tbpwb_pkg::item_t   item_s1;
	logic               valid_s1;
	logic               phase_q;
	tbpwb_pkg::result_t result_q;
	logic               result_valid_q;
	tbpwb_pkg::result_t enc_result;
	logic               enc_two;
	logic               accept;
	logic               hold;

	tbpwb_encoder #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_encoder (
		.item      (item_s1),
		.phase     (phase_q),
		.result    (enc_result),
		.two_words (enc_two)
	);

	// hold the request to emit the second word
	assign hold   = valid_s1 && enc_two && !phase_q;
	assign busy   = hold;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			phase_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
			if (hold) begin
				phase_q <= 1'b1;
			end else begin
				phase_q  <= 1'b0;
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (valid_s1) begin
			result_q <= enc_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_busy_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s1)
		else $error("busy without a held request");

	a_phase_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_s1)
		else $error("second word phase without a held request");

	a_item_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> result_valid_q)
		else $error("held request produced no result word");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.last) |=> (result_valid_q && result_q.last))
		else $error("second result word did not follow");

	a_overflow_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.slot_overflow) |-> result_q.last)
		else $error("slot overflow on a non-final word");

endmodule

>>> sv/tbpwb_encoder.sv
// ----------------------------------------------------------------------------
// tbpwb_encoder: branch encoding and result word formation
// Encodes a B.W (T4) / BL (T1) branch from patch to target and forms the result
// word for the selected phase of a patch request.
// ----------------------------------------------------------------------------
module tbpwb_encoder #(
	parameter int SLOT_COUNT = 8
) (
	input  tbpwb_pkg::item_t   item,
	input  logic               phase,
	output tbpwb_pkg::result_t result,
	output logic               two_words
);

	logic [tbpwb_pkg::ADDR_W-1:0] patch;
	logic [tbpwb_pkg::ADDR_W-1:0] target;
	logic [tbpwb_pkg::ADDR_W-1:0] imm;
	logic                         s_bit;
	logic                         j1;
	logic                         j2;
	logic                         oor;
	logic [tbpwb_pkg::HALF_W-1:0] first_half;
	logic [tbpwb_pkg::HALF_W-1:0] second_half;
	logic [tbpwb_pkg::SLOT_W:0]   slot_ext;
	logic [tbpwb_pkg::SLOT_W:0]   slot_next_ext;
	logic                         base_ovf;
	logic                         half_ovf;
	logic [tbpwb_pkg::ADDR_W-3:0] base_word;

	always_comb begin
		patch  = {item.patch_address[tbpwb_pkg::ADDR_W-1:1], 1'b0};
		target = {item.target_address[tbpwb_pkg::ADDR_W-1:1], 1'b0};
		imm    = target - (patch + tbpwb_pkg::WORD_STEP);
		// offset fits when bits 31..24 are a pure sign extension
		oor    = !((imm[31:24] == 8'h00) || (imm[31:24] == 8'hFF));
		s_bit  = imm[24];
		j1     = ~(imm[23] ^ s_bit);
		j2     = ~(imm[22] ^ s_bit);
		first_half  = {tbpwb_pkg::BR_PREFIX, s_bit, imm[21:12]};
		second_half = {tbpwb_pkg::BR_LO_TOP, item.with_link, j1,
			tbpwb_pkg::BR_LO_FIXED, j2, imm[11:1]};

		slot_ext      = {1'b0, item.slot_index};
		slot_next_ext = slot_ext + 4'd1;
		base_ovf      = slot_ext >= 4'(SLOT_COUNT);
		half_ovf      = base_ovf || (slot_next_ext >= 4'(SLOT_COUNT));
		two_words     = patch[1] && !half_ovf;
		base_word     = patch[tbpwb_pkg::ADDR_W-1:2];

		result.offset_out_of_range = oor;
		if (!patch[1]) begin
			result.slot             = item.slot_index;
			result.comparator_value = {patch[tbpwb_pkg::ADDR_W-1:1], 1'b1};
			result.remap_word       = {second_half, first_half};
			result.slot_overflow    = base_ovf;
			result.last             = 1'b1;
		end else if (!phase) begin
			result.slot             = item.slot_index;
			result.comparator_value = {base_word, tbpwb_pkg::CMP_ENABLE};
			result.remap_word       = {first_half, item.original_low_word[15:0]};
			result.slot_overflow    = half_ovf;
			result.last             = !two_words;
		end else begin
			result.slot             = slot_next_ext[tbpwb_pkg::SLOT_W-1:0];
			result.comparator_value = {base_word + 30'd1, tbpwb_pkg::CMP_ENABLE};
			result.remap_word       = {item.original_high_word[31:16], second_half};
			result.slot_overflow    = 1'b0;
			result.last             = 1'b1;
		end
	end

endmodule
